FILE: hw/rtl/bba_pkg.sv
package bba_pkg;

    // Bitmap geometry: one bit per block, stored in wide memory words that are
    // summarised by one full flag each; flags are grouped into summary words.
    localparam int MAX_BLOCKS  = 65536;
    localparam int BLK_W       = 16;
    localparam int CNT_W       = 17;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int WORDS       = MAX_BLOCKS / WORD_BITS;
    localparam int WADDR_W     = 10;
    localparam int FLAGS       = 32;
    localparam int FLAG_W      = 5;
    localparam int GROUPS      = WORDS / FLAGS;
    localparam int GADDR_W     = 5;
    localparam int FW_W        = CNT_W - BIT_W;

    // Command codes.
    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_FREE   = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_FORMAT = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef struct packed {
        logic [2:0]       op;
        logic [BLK_W-1:0] block_number;
        logic             bit_value;
    } bba_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] result_block;
        logic             read_value;
        logic [CNT_W-1:0] free_count;
    } bba_out_t;

endpackage

FILE: hw/rtl/bitmap_block_allocator.sv
// Path from the accepting edge to the result strobe: allocate passes through the summary
// lookup and the bit stage; free, read bit and write bit through the bit stage; rejected or
// undefined commands answer from idle; format writes all WORDS (1024) words, one per cycle.
// One command at a time; a new one may be accepted in the cycle its result shows.
// Reset is asynchronous; after it a clearing pass over all WORDS words runs with busy high.
// The done strobe is high for one cycle only: the receiver cannot stall. The result is held until the next accept.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bba_in_t             cmd,
    output logic                done,
    output bba_out_t            result,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CNT_W-1:0]    cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_AMID = 2'd1;
    localparam logic [1:0] S_BIT  = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    // Lowest clear bit of a summary word.
    function automatic logic [FLAG_W-1:0] ffz_flags(input logic [FLAGS-1:0] v);
        logic [FLAG_W-1:0] idx;
        idx = '0;
        for (int i = FLAGS - 1; i >= 0; i--)
        begin
            if (!v[i])
                idx = FLAG_W'(i);
        end
        return idx;
    endfunction

    // Lowest clear bit of a bitmap word.
    function automatic logic [BIT_W-1:0] ffz_word(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!v[i])
                idx = BIT_W'(i);
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0] bm_mem [WORDS];
    logic [FLAGS-1:0]     mid_mem [GROUPS];

    logic [WORD_BITS-1:0] bm_rdata_reg;
    logic [FLAGS-1:0]     mid_rdata_reg;

    logic [1:0]           state_reg, state_next;
    logic [WADDR_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]     r_reg, r_next;
    logic                 fmt_reply_reg, fmt_reply_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     reserved_reg, reserved_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [GROUPS-1:0]    top_reg, top_next;
    logic                 done_reg, done_next;

    logic [2:0]           op_reg, op_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic                 bitv_reg, bitv_next;
    logic [CNT_W-1:0]     tot_reg, tot_next;
    logic [WADDR_W-1:0]   word_reg, word_next;
    bba_out_t             result_reg, result_next;

    logic                 bm_we;
    logic [WADDR_W-1:0]   bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic                 mid_we;
    logic [GADDR_W-1:0]   mid_waddr, mid_raddr;
    logic [FLAGS-1:0]     mid_wdata;

    logic                 accept;
    logic [CNT_W-1:0]     tot_in;
    logic [CNT_W-1:0]     r_in;
    logic [GADDR_W-1:0]   grp_free;
    logic                 in_range;
    logic [FW_W-1:0]      fw_in;
    logic [FW_W-1:0]      fw_cur;
    logic [BIT_W-1:0]     bit_sel;
    logic [BLK_W-1:0]     blk_found;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] word_mod;
    logic [FLAGS-1:0]     mid_mod;
    logic [FLAG_W-1:0]    flag_sel;
    logic [GADDR_W-1:0]   grp_cur;

    assign accept   = start && !busy;
    assign tot_in   = (total_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_reg;
    assign r_in     = (reserved_reg < tot_in) ? reserved_reg : tot_in;
    assign fw_in    = r_in[CNT_W-1:BIT_W];
    assign fw_cur   = r_reg[CNT_W-1:BIT_W];
    assign grp_free = ffz_flags(top_reg);
    assign in_range = {1'b0, cmd.block_number} < tot_in;
    assign grp_cur  = word_reg[WADDR_W-1 -: GADDR_W];
    assign flag_sel = word_reg[FLAG_W-1:0];

    // Bit addressed in the bit stage: the first clear bit for allocate.
    assign bit_sel   = (op_reg == OP_ALLOC) ? ffz_word(bm_rdata_reg) : blk_reg[BIT_W-1:0];
    assign blk_found = {word_reg, bit_sel};
    assign bit_mask  = WORD_BITS'(1) << bit_sel;

    // Memory read addresses: commands read at the accepting edge.
    always_comb
    begin
        bm_raddr  = word_reg;
        mid_raddr = grp_cur;
        case (state_reg)
            S_IDLE:
            begin
                bm_raddr  = cmd.block_number[BLK_W-1 -: WADDR_W];
                mid_raddr = (cmd.op == OP_ALLOC) ? grp_free
                                                 : cmd.block_number[BLK_W-1 -: GADDR_W];
            end
            S_AMID:
            begin
                bm_raddr  = {grp_cur, ffz_flags(mid_rdata_reg)};
                mid_raddr = grp_cur;
            end
            default:
            begin
                bm_raddr  = word_reg;
                mid_raddr = grp_cur;
            end
        endcase
    end

    // Main control and the read-modify-write of the bit stage.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        fmt_reply_next = fmt_reply_reg;
        total_next     = total_reg;
        reserved_next  = reserved_reg;
        free_next      = free_reg;
        top_next       = top_reg;
        done_next      = 1'b0;
        op_next        = op_reg;
        blk_next       = blk_reg;
        bitv_next      = bitv_reg;
        tot_next       = tot_reg;
        word_next      = word_reg;
        result_next    = result_reg;

        bm_we     = 1'b0;
        bm_waddr  = word_reg;
        bm_wdata  = '0;
        mid_we    = 1'b0;
        mid_waddr = grp_cur;
        mid_wdata = '0;

        word_mod = bm_rdata_reg;
        mid_mod  = mid_rdata_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL)
                total_next = cfg_data;
            else
                reserved_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.op;
                    blk_next    = cmd.block_number;
                    bitv_next   = cmd.bit_value;
                    tot_next    = tot_in;
                    word_next   = cmd.block_number[BLK_W-1 -: WADDR_W];
                    result_next.status       = ST_OK;
                    result_next.result_block = '0;
                    result_next.read_value   = 1'b0;
                    result_next.free_count   = free_reg;
                    case (cmd.op)
                        OP_ALLOC:
                        begin
                            if (free_reg == '0 || (&top_reg))
                            begin
                                result_next.status = ST_NOFREE;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                word_next  = {grp_free, FLAG_W'(0)};
                                state_next = S_AMID;
                            end
                        end
                        OP_FREE, OP_READ, OP_WRITE:
                        begin
                            result_next.result_block = cmd.block_number;
                            if (!in_range)
                            begin
                                result_next.status = ST_RANGE;
                                done_next          = 1'b1;
                            end
                            else
                                state_next = S_BIT;
                        end
                        OP_FORMAT:
                        begin
                            r_next         = r_in;
                            free_next      = tot_in - r_in;
                            result_next.free_count = tot_in - r_in;
                            fmt_reply_next = 1'b1;
                            cnt_next       = '0;
                            for (int g = 0; g < GROUPS; g++)
                                top_next[g] = {1'b0, GADDR_W'(g), {FLAG_W{1'b1}}} < fw_in;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_AMID:
            begin
                word_next  = {grp_cur, ffz_flags(mid_rdata_reg)};
                state_next = S_BIT;
            end

            S_BIT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if ({1'b0, blk_found} >= tot_reg)
                            result_next.status = ST_NOFREE;
                        else
                        begin
                            word_mod = bm_rdata_reg | bit_mask;
                            bm_we    = 1'b1;
                            free_next = free_reg - CNT_W'(1);
                            result_next.result_block = blk_found;
                        end
                    end
                    OP_FREE:
                    begin
                        word_mod = bm_rdata_reg & ~bit_mask;
                        bm_we    = 1'b1;
                        if (free_reg < tot_reg)
                            free_next = free_reg + CNT_W'(1);
                    end
                    OP_WRITE:
                    begin
                        word_mod = bitv_reg ? (bm_rdata_reg | bit_mask)
                                            : (bm_rdata_reg & ~bit_mask);
                        bm_we    = 1'b1;
                    end
                    default:
                    begin
                        result_next.read_value = bm_rdata_reg[bit_sel];
                    end
                endcase
                // Keep the full flags of the word and its group in step.
                mid_mod[flag_sel] = &word_mod;
                bm_wdata  = word_mod;
                mid_wdata = mid_mod;
                mid_we    = bm_we;
                if (bm_we)
                    top_next[grp_cur] = &mid_mod;
                result_next.free_count = free_next;
            end

            default:
            begin
                // Sweep: rewrite every bitmap word and the summary words with the leading reserved blocks set.
                bm_we    = 1'b1;
                bm_waddr = cnt_reg;
                if ({1'b0, cnt_reg} < fw_cur)
                    bm_wdata = '1;
                else if ({1'b0, cnt_reg} == fw_cur)
                    bm_wdata = (WORD_BITS'(1) << r_reg[BIT_W-1:0]) - WORD_BITS'(1);
                else
                    bm_wdata = '0;
                mid_we    = (cnt_reg[WADDR_W-1:FLAG_W] == '0);
                mid_waddr = cnt_reg[GADDR_W-1:0];
                for (int j = 0; j < FLAGS; j++)
                    mid_wdata[j] = {1'b0, cnt_reg[GADDR_W-1:0], FLAG_W'(j)} < fw_cur;
                cnt_next = cnt_reg + WADDR_W'(1);
                if (cnt_reg == WADDR_W'(WORDS - 1))
                begin
                    state_next     = S_IDLE;
                    done_next      = fmt_reply_reg;
                    fmt_reply_next = 1'b0;
                end
            end
        endcase
    end

    // Bitmap and summary memories, registered read.
    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_waddr] <= bm_wdata;
        bm_rdata_reg <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
            mid_mem[mid_waddr] <= mid_wdata;
        mid_rdata_reg <= mid_mem[mid_raddr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            r_reg         <= '0;
            fmt_reply_reg <= 1'b0;
            total_reg     <= CNT_W'(MAX_BLOCKS);
            reserved_reg  <= '0;
            free_reg      <= CNT_W'(MAX_BLOCKS);
            top_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            r_reg         <= r_next;
            fmt_reply_reg <= fmt_reply_next;
            total_reg     <= total_next;
            reserved_reg  <= reserved_next;
            free_reg      <= free_next;
            top_reg       <= top_next;
            done_reg      <= done_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        blk_reg    <= blk_next;
        bitv_reg   <= bitv_next;
        tot_reg    <= tot_next;
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    // A result beat is only shown once the command has finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result strobe while a command is still running");

    // The free counter never exceeds the size of the map.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CNT_W'(MAX_BLOCKS))
        else $error("free counter above map size");

    // An allocate that can succeed goes on to the summary lookup.
    a_alloc_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_ALLOC && free_reg != '0 && !(&top_reg))
        |=> state_reg == S_AMID)
        else $error("allocate did not start its summary lookup");

    // Allocation never hands out a block at or above the total.
    a_alloc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg == OP_ALLOC && result.status == ST_OK && $past(state_reg) == S_BIT)
        |-> {1'b0, result.result_block} < tot_reg)
        else $error("allocated block beyond the managed range");
`endif

endmodule
